// ----- rtl/msl_pkg.sv -----
// Package for the midpoint subdivision line plotter.
// Holds command codes, coordinate widths, the segment type and the controller states.
// No dependencies.
package msl_pkg;

    localparam int COORD_W = 6;

    localparam logic [1:0] CMD_DRAW  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef logic [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord ax;
        t_coord ay;
        t_coord bx;
        t_coord by;
    } t_seg;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_SEG,
        ST_WR_B,
        ST_RD_A,
        ST_WR_A,
        ST_POP
    } t_state;

endpackage

// ----- rtl/msl_canvas_ram.sv -----
// Canvas store: one row of pixels per entry, one write and one read port.
// Read data is registered and holds until the next read. No dependencies.
module msl_canvas_ram #(
    parameter int ROWS = 60,
    parameter int COLS = 60
) (
    input  logic                    i_clk,
    input  logic                    i_rd_en,
    input  logic [$clog2(ROWS)-1:0] i_rd_addr,
    output logic [COLS-1:0]         o_rd_data,
    input  logic                    i_wr_en,
    input  logic [$clog2(ROWS)-1:0] i_wr_addr,
    input  logic [COLS-1:0]         i_wr_data
);

    logic [COLS-1:0] r_mem [ROWS];
    logic [COLS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/msl_stack_ram.sv -----
// Pending segment stack store, one write and one read port, registered read.
// Depends on msl_pkg for the segment type.
module msl_stack_ram import msl_pkg::*; #(
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output t_seg                     o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  t_seg                     i_wr_data
);

    t_seg r_mem [DEPTH];
    t_seg r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/midpoint_subdivision_line_plotter_top.sv -----
// Midpoint subdivision line plotter: controller over a row-wide canvas RAM and a segment stack RAM.
// Depends on msl_pkg, msl_canvas_ram and msl_stack_ram.
// Draw: each leaf costs two read-modify-write passes on the canvas port;
// rejected or unused commands are answered straight from the idle state.
// One command at a time; busy stays high until its result strobe. The receiver cannot stall.
// Reset: synchronous; a clearing pass over every canvas row follows, with busy high.
module midpoint_subdivision_line_plotter_top import msl_pkg::*; #(
    parameter int CANVAS_DIM = 60,
    parameter int STACK_DEPTH = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    input  logic [1:0]   i_cmd,
    input  logic [5:0]   i_start_x,
    input  logic [5:0]   i_start_y,
    input  logic [5:0]   i_end_x,
    input  logic [5:0]   i_end_y,
    output logic         o_valid,
    output logic         o_pixel_value,
    output logic         o_status
);

    localparam int AW = $clog2(CANVAS_DIM);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(STACK_DEPTH + 1);
    localparam logic [COORD_W:0] LIMIT    = (COORD_W + 1)'(CANVAS_DIM);
    localparam logic [AW-1:0]    LAST_ROW = AW'(CANVAS_DIM - 1);
    localparam logic [PW-1:0]    FULL     = PW'(STACK_DEPTH);

    t_state          r_state, n_state;
    t_seg            r_seg, n_seg;
    logic [PW-1:0]   r_sp, n_sp;
    logic [AW-1:0]   r_cnt, n_cnt;
    logic            r_valid, n_valid;
    logic            r_pix, n_pix;
    logic            r_stat, n_stat;

    logic            cv_rd_en, cv_wr_en;
    logic [AW-1:0]   cv_rd_addr, cv_wr_addr;
    logic [CANVAS_DIM-1:0] cv_rd_data, cv_wr_data;
    logic            st_rd_en, st_wr_en;
    logic [SW-1:0]   st_rd_addr, st_wr_addr;
    t_seg            st_rd_data, st_wr_data;

    logic            start_bad, end_bad, leaf;
    logic [COORD_W:0] dx, dy, sum_x, sum_y;
    t_coord          mx, my;
    logic [PW-1:0]   sp_dec;

    msl_canvas_ram #(.ROWS(CANVAS_DIM), .COLS(CANVAS_DIM)) u_canvas (
        .i_clk     (i_clk),
        .i_rd_en   (cv_rd_en),
        .i_rd_addr (cv_rd_addr),
        .o_rd_data (cv_rd_data),
        .i_wr_en   (cv_wr_en),
        .i_wr_addr (cv_wr_addr),
        .i_wr_data (cv_wr_data)
    );

    msl_stack_ram #(.DEPTH(STACK_DEPTH)) u_stack (
        .i_clk     (i_clk),
        .i_rd_en   (st_rd_en),
        .i_rd_addr (st_rd_addr),
        .o_rd_data (st_rd_data),
        .i_wr_en   (st_wr_en),
        .i_wr_addr (st_wr_addr),
        .i_wr_data (st_wr_data)
    );

    assign start_bad = ({1'b0, i_start_x} >= LIMIT) || ({1'b0, i_start_y} >= LIMIT);
    assign end_bad   = ({1'b0, i_end_x} >= LIMIT) || ({1'b0, i_end_y} >= LIMIT);

    assign dx    = {1'b0, r_seg.ax} - {1'b0, r_seg.bx};
    assign dy    = {1'b0, r_seg.ay} - {1'b0, r_seg.by};
    assign leaf  = (dx == '0 || dx == (COORD_W + 1)'(1) || dx == '1) &&
                   (dy == '0 || dy == (COORD_W + 1)'(1) || dy == '1);
    assign sum_x = {1'b0, r_seg.ax} + {1'b0, r_seg.bx};
    assign sum_y = {1'b0, r_seg.ay} + {1'b0, r_seg.by};
    assign mx    = sum_x[COORD_W:1];
    assign my    = sum_y[COORD_W:1];
    assign sp_dec = r_sp - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_sp    <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seg  <= n_seg;
        r_pix  <= n_pix;
        r_stat <= n_stat;
    end

    always_comb begin
        n_state    = r_state;
        n_seg      = r_seg;
        n_sp       = r_sp;
        n_cnt      = r_cnt;
        n_valid    = 1'b0;
        n_pix      = 1'b0;
        n_stat     = 1'b0;
        cv_rd_en   = 1'b0;
        cv_rd_addr = r_seg.bx[AW-1:0];
        cv_wr_en   = 1'b0;
        cv_wr_addr = r_seg.bx[AW-1:0];
        cv_wr_data = cv_rd_data | (CANVAS_DIM'(1) << r_seg.by);
        st_rd_en   = 1'b0;
        st_rd_addr = sp_dec[SW-1:0];
        st_wr_en   = 1'b0;
        st_wr_addr = r_sp[SW-1:0];
        st_wr_data = '{ax: mx, ay: my, bx: r_seg.bx, by: r_seg.by};

        unique case (r_state) inside
            ST_INIT, ST_CLEAR: begin
                cv_wr_en   = 1'b1;
                cv_wr_addr = r_cnt;
                cv_wr_data = '0;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == LAST_ROW) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                    n_valid = (r_state == ST_CLEAR);
                end
            end
            ST_IDLE: begin
                if (start) begin
                    n_seg = '{ax: i_start_x, ay: i_start_y, bx: i_end_x, by: i_end_y};
                    unique case (i_cmd)
                        CMD_DRAW: begin
                            if (start_bad || end_bad) begin
                                n_valid = 1'b1;
                                n_stat  = 1'b1;
                            end else begin
                                n_sp    = '0;
                                n_state = ST_SEG;
                            end
                        end
                        CMD_READ: begin
                            if (start_bad) begin
                                n_valid = 1'b1;
                                n_stat  = 1'b1;
                            end else begin
                                cv_rd_en   = 1'b1;
                                cv_rd_addr = i_start_x[AW-1:0];
                                n_state    = ST_READ;
                            end
                        end
                        CMD_CLEAR: begin
                            n_cnt   = '0;
                            n_state = ST_CLEAR;
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_valid = 1'b1;
                n_pix   = cv_rd_data[r_seg.ay[AW-1:0]];
                n_state = ST_IDLE;
            end
            ST_SEG: begin
                if (leaf) begin
                    cv_rd_en   = 1'b1;
                    cv_rd_addr = r_seg.bx[AW-1:0];
                    n_state    = ST_WR_B;
                end else begin
                    if (r_sp != FULL) begin
                        st_wr_en = 1'b1;
                        n_sp     = r_sp + 1'b1;
                    end
                    n_seg = '{ax: mx, ay: my, bx: r_seg.ax, by: r_seg.ay};
                end
            end
            ST_WR_B: begin
                cv_wr_en = 1'b1;
                n_state  = ST_RD_A;
            end
            ST_RD_A: begin
                cv_rd_en   = 1'b1;
                cv_rd_addr = r_seg.ax[AW-1:0];
                n_state    = ST_WR_A;
            end
            ST_WR_A: begin
                cv_wr_en   = 1'b1;
                cv_wr_addr = r_seg.ax[AW-1:0];
                cv_wr_data = cv_rd_data | (CANVAS_DIM'(1) << r_seg.ay);
                if (r_sp == '0) begin
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    st_rd_en = 1'b1;
                    n_sp     = sp_dec;
                    n_state  = ST_POP;
                end
            end
            ST_POP: begin
                n_seg   = st_rd_data;
                n_state = ST_SEG;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_valid       = r_valid;
    assign o_pixel_value = r_pix;
    assign o_status      = r_stat;

endmodule
